>>> src/lctp_pkg.sv
// Shared types and constants for the LED command text parser.
package lctp_pkg;

    localparam int CharW   = 8;
    localparam int ColW    = 24;
    localparam int CfgIdxW = 3;

    localparam int QueueDepth = 4;
    localparam int PtrW       = $clog2(QueueDepth);

    localparam logic [7:0]      ResetMode   = 8'd0;
    localparam logic [7:0]      ResetSpeed  = 8'd2;
    localparam logic [7:0]      ResetBright = 8'd90;
    localparam logic [7:0]      ResetDir    = 8'd1;
    localparam logic [ColW-1:0] ResetRgb    = 24'h4080FF;

    typedef enum logic [1:0] {
        KIND_ZONE  = 2'd0,
        KIND_MODE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_BAD_CMD     = 2'd0,
        ERR_MISPLACED_X = 2'd1,
        ERR_RANGE       = 2'd2,
        ERR_NO_NUMBER   = 2'd3
    } err_code_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE   = 3'd0,
        CFG_SPEED  = 3'd1,
        CFG_BRIGHT = 3'd2,
        CFG_DIR    = 3'd3,
        CFG_RGB    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        kind_t           kind;
        logic [7:0]      zone_mask;
        logic [ColW-1:0] rgb;
        logic [3:0][7:0] pf;
        err_code_t       code;
        logic            run_end;
    } res_t;

    // Up to two results written into the queue by one processed byte.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } res_wr_t;

endpackage

>>> src/lctp_parser.sv
// Input register, parse state and per-byte command decode.
module lctp_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lctp_pkg::CharW-1:0]     char_in,
    input  logic                           last_byte,
    input  logic                           wr_en,
    input  logic [lctp_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [lctp_pkg::ColW-1:0]      wr_data,
    input  logic                           room,
    output lctp_pkg::res_wr_t              res_wr
);
    import lctp_pkg::*;

    typedef enum logic {
        PH_CMD = 1'b0,
        PH_NUM = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        TG_MODE   = 3'd0,
        TG_SPEED  = 3'd1,
        TG_BRIGHT = 3'd2,
        TG_DIR    = 3'd3,
        TG_ZONE   = 3'd4,
        TG_MCOL   = 3'd5,
        TG_ZCOL   = 3'd6
    } target_t;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        phase_t          phase;
        target_t         target;
        logic [7:0]      acc;
        radix_t          radix;
        logic [1:0]      dcnt;
        logic [1:0]      cidx;
        logic [7:0]      zbits;
        logic [ColW-1:0] zcol;
        logic [3:0][7:0] pf;
        logic [ColW-1:0] pcol;
    } ps_t;

    localparam ps_t PsReset = '{
        phase:  PH_CMD,
        target: TG_MODE,
        acc:    8'd0,
        radix:  RAD_DEC,
        dcnt:   2'd0,
        cidx:   2'd0,
        zbits:  8'd0,
        zcol:   '0,
        pf:     {ResetDir, ResetBright, ResetSpeed, ResetMode},
        pcol:   ResetRgb
    };

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChLf    = 8'h0a;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch7     = 8'h37;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5a;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChB     = 8'h62;
    localparam logic [7:0] ChC     = 8'h63;
    localparam logic [7:0] ChD     = 8'h64;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChM     = 8'h6d;
    localparam logic [7:0] ChV     = 8'h76;
    localparam logic [7:0] ChX     = 8'h78;
    localparam logic [7:0] ChZ     = 8'h7a;
    localparam logic [7:0] CaseGap = 8'h20;

    function automatic ps_t start_num(input ps_t s, input target_t t);
        ps_t r;
        r        = s;
        r.phase  = PH_NUM;
        r.target = t;
        r.acc    = '0;
        r.radix  = RAD_DEC;
        r.dcnt   = '0;
        return r;
    endfunction

    function automatic ps_t clear_parse(input ps_t s);
        ps_t r;
        r        = s;
        r.phase  = PH_CMD;
        r.target = TG_MODE;
        r.acc    = '0;
        r.radix  = RAD_DEC;
        r.dcnt   = '0;
        r.cidx   = '0;
        return r;
    endfunction

    // Component index 0 is red, 1 green, 2 blue; index 3 wraps to red.
    function automatic logic [ColW-1:0] set_comp(input logic [ColW-1:0] rgb,
                                                 input logic [1:0] idx,
                                                 input logic [7:0] v);
        logic [ColW-1:0] r;
        r = rgb;
        case (idx)
            2'd1:    r[15:8]  = v;
            2'd2:    r[7:0]   = v;
            default: r[23:16] = v;
        endcase
        return r;
    endfunction

    function automatic void cmd_byte(input ps_t s, input logic [7:0] c,
                                     output ps_t r, output logic bad);
        ps_t t;
        r   = s;
        bad = 1'b0;
        t   = s;
        case (c)
            ChSpace, ChLf: r = s;
            ChM:           r = start_num(s, TG_MODE);
            ChV:           r = start_num(s, TG_SPEED);
            ChB:           r = start_num(s, TG_BRIGHT);
            ChD:           r = start_num(s, TG_DIR);
            ChC:
            begin
                t.cidx = '0;
                r      = start_num(t, TG_MCOL);
            end
            ChZ:           r = start_num(s, TG_ZONE);
            default:       bad = 1'b1;
        endcase
    endfunction

    function automatic void num_byte(input ps_t s, input logic [7:0] c,
                                     output ps_t r, output logic err,
                                     output err_code_t code, output logic fin);
        logic [3:0]  d;
        logic        dv;
        logic [11:0] v;
        r    = s;
        err  = 1'b0;
        code = ERR_BAD_CMD;
        fin  = 1'b0;
        d    = c[3:0];
        dv   = 1'b0;
        if (c inside {[Ch0:Ch9]})
        begin
            dv = (s.radix != RAD_OCT) || (c <= Ch7);
        end
        else if (s.radix == RAD_HEX && (c inside {[ChA:ChF]}))
        begin
            // Letters a..f carry 1..6 in their low nibble.
            d  = c[3:0] + 4'd9;
            dv = 1'b1;
        end
        case (s.radix)
            RAD_OCT: v = {1'b0, s.acc, 3'b000};
            RAD_HEX: v = {s.acc, 4'b0000};
            default: v = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0};
        endcase
        v = v + {8'd0, d};

        if (c == ChSpace && s.dcnt == 2'd0)
        begin
            r = s;
        end
        else if (c == ChX && s.acc == 8'd0)
        begin
            if (s.dcnt == 2'd0)
                r.radix = RAD_OCT;
            else if (s.dcnt == 2'd1)
                r.radix = RAD_HEX;
            else
            begin
                err  = 1'b1;
                code = ERR_MISPLACED_X;
            end
        end
        else if (dv)
        begin
            if (v > 12'd255)
            begin
                err  = 1'b1;
                code = ERR_RANGE;
            end
            else
            begin
                r.acc = v[7:0];
                if (s.dcnt < 2'd2)
                    r.dcnt = s.dcnt + 2'd1;
            end
        end
        else if (s.dcnt == 2'd0)
        begin
            err  = 1'b1;
            code = ERR_NO_NUMBER;
        end
        else
        begin
            fin = 1'b1;
        end
    endfunction

    function automatic void finish_num(input ps_t s, output ps_t r, output logic zone);
        ps_t        t;
        logic [7:0] am1;
        t     = s;
        t.phase = PH_CMD;
        zone  = 1'b0;
        am1   = s.acc - 8'd1;
        r     = t;
        case (s.target)
            TG_MODE, TG_SPEED, TG_BRIGHT, TG_DIR:
            begin
                r.pf[s.target[1:0]] = s.acc;
            end
            TG_ZONE:
            begin
                // Zone 0 and zones above 8 select no zone at all.
                t.zbits = (s.acc >= 8'd1 && s.acc <= 8'd8) ? (8'd1 << am1[2:0]) : 8'd0;
                t.cidx  = '0;
                r       = start_num(t, TG_ZCOL);
            end
            TG_MCOL:
            begin
                t.pcol = set_comp(s.pcol, s.cidx, s.acc);
                r      = t;
                if (s.cidx < 2'd2)
                begin
                    t.cidx = s.cidx + 2'd1;
                    r      = start_num(t, TG_MCOL);
                end
            end
            default:
            begin
                t.zcol = set_comp(s.zcol, s.cidx, s.acc);
                r      = t;
                if (s.cidx < 2'd2)
                begin
                    t.cidx = s.cidx + 2'd1;
                    r      = start_num(t, TG_ZCOL);
                end
                else
                begin
                    zone = 1'b1;
                end
            end
        endcase
    endfunction

    ps_t                   ps_reg, ps_next;
    logic                  discard_reg, discard_next;
    logic                  open_reg, open_next;
    logic                  in_vld_reg;
    logic [CharW-1:0]      in_char_reg;
    logic                  in_last_reg;
    logic [3:0][7:0]       def_pf_reg;
    logic [ColW-1:0]       def_rgb_reg;
    logic                  fire;

    assign fire     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_char_reg <= char_in;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_pf_reg  <= {ResetDir, ResetBright, ResetSpeed, ResetMode};
            def_rgb_reg <= ResetRgb;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_MODE:   def_pf_reg[0] <= wr_data[7:0];
                CFG_SPEED:  def_pf_reg[1] <= wr_data[7:0];
                CFG_BRIGHT: def_pf_reg[2] <= wr_data[7:0];
                CFG_DIR:    def_pf_reg[3] <= wr_data[7:0];
                CFG_RGB:    def_rgb_reg   <= wr_data;
                default:    def_rgb_reg   <= def_rgb_reg;
            endcase
        end
    end

    always_comb
    begin : step
        logic [7:0] c;
        ps_t        p, q, q2, q3;
        logic       err, bad, fin, fin2, zone, zone_end, zone_any, mode;
        err_code_t  code, code2;
        logic       err2;
        res_t       zone_res, mode_res, err_res;
        logic [1:0] cnt;

        c = in_char_reg;
        if (c inside {[ChUpA:ChUpZ]})
            c = c + CaseGap;

        // The first byte of a message picks up the configured defaults.
        p = ps_reg;
        if (!open_reg)
        begin
            p      = clear_parse(ps_reg);
            p.pf   = def_pf_reg;
            p.pcol = def_rgb_reg;
        end

        err      = 1'b0;
        bad      = 1'b0;
        fin      = 1'b0;
        fin2     = 1'b0;
        err2     = 1'b0;
        zone     = 1'b0;
        zone_end = 1'b0;
        code     = ERR_BAD_CMD;
        code2    = ERR_BAD_CMD;
        q2       = p;
        q3       = p;

        if (p.phase == PH_CMD)
        begin
            cmd_byte(p, c, q, bad);
            err = bad;
        end
        else
        begin
            num_byte(p, c, q, err, code, fin);
            if (fin)
            begin
                // The byte that ended the number is read once more.
                finish_num(q, q2, zone);
                if (q2.phase == PH_CMD)
                begin
                    cmd_byte(q2, c, q, bad);
                    err  = bad;
                    code = ERR_BAD_CMD;
                end
                else
                begin
                    // A freshly started number has no digit, so it cannot end here.
                    num_byte(q2, c, q, err2, code2, fin2);
                    err  = err2 || fin2;
                    code = code2;
                end
            end
        end

        mode = 1'b0;
        if (!err && in_last_reg)
        begin
            if (q.phase == PH_NUM)
            begin
                if (q.dcnt == 2'd0)
                begin
                    err  = 1'b1;
                    code = ERR_NO_NUMBER;
                end
                else
                begin
                    finish_num(q, q3, zone_end);
                    q = q3;
                    if (q.phase == PH_NUM)
                    begin
                        err  = 1'b1;
                        code = ERR_NO_NUMBER;
                    end
                end
            end
            mode = !err;
        end

        zone_any = zone || zone_end;

        zone_res           = '0;
        zone_res.kind      = KIND_ZONE;
        zone_res.zone_mask = q.zbits;
        zone_res.rgb       = q.zcol;

        mode_res      = '0;
        mode_res.kind = KIND_MODE;
        mode_res.rgb  = q.pcol;
        mode_res.pf   = q.pf;

        err_res      = '0;
        err_res.kind = KIND_ERROR;
        err_res.code = code;

        cnt = {1'b0, zone_any} + {1'b0, mode} + {1'b0, err};

        res_wr.first  = zone_any ? zone_res : (mode ? mode_res : err_res);
        res_wr.second = (zone_any && mode) ? mode_res : err_res;
        if (cnt == 2'd2)
            res_wr.second.run_end = 1'b1;
        else
            res_wr.first.run_end = 1'b1;

        ps_next      = ps_reg;
        discard_next = discard_reg;
        open_next    = open_reg;
        res_wr.count = 2'd0;
        if (fire)
        begin
            if (discard_reg)
            begin
                if (in_last_reg)
                begin
                    discard_next = 1'b0;
                    open_next    = 1'b0;
                end
            end
            else
            begin
                res_wr.count = cnt;
                ps_next      = q;
                open_next    = 1'b1;
                if (err)
                begin
                    ps_next      = clear_parse(q);
                    open_next    = 1'b0;
                    discard_next = !in_last_reg;
                end
                else if (in_last_reg)
                begin
                    ps_next   = clear_parse(q);
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg      <= PsReset;
            discard_reg <= 1'b0;
            open_reg    <= 1'b0;
        end
        else
        begin
            ps_reg      <= ps_next;
            discard_reg <= discard_next;
            open_reg    <= open_next;
        end
    end

endmodule

>>> src/lctp_result_queue.sv
// Small result queue: takes up to two results a cycle, hands out one unless stalled.
module lctp_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  lctp_pkg::res_wr_t res_wr,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output lctp_pkg::res_t    head
);
    import lctp_pkg::*;

    res_t            mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            pop;
    logic [PtrW-1:0] wr_ptr_inc;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign head       = mem_reg[rd_ptr_reg];
    // Room is kept for a full two-result write.
    assign room       = (count_reg <= (PtrW+1)'(QueueDepth - 2));
    assign wr_ptr_inc = wr_ptr_reg + PtrW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(res_wr.count);
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(res_wr.count) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res_wr.count != 2'd0)
            mem_reg[wr_ptr_reg] <= res_wr.first;
        if (res_wr.count == 2'd2)
            mem_reg[wr_ptr_inc] <= res_wr.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/led_command_text_parser.sv
// Top level of the LED command text parser.
//
// Input channel: one text byte per transfer on char_in, with last_byte set on
// the final byte of a message. Output channel: one result per transfer (zone
// packet, mode packet or error), run_end set on the last result of a byte.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// A byte is held in the input register, then decoded and written into the
// result queue, from whose head its first result is shown.
// Throughput: one byte per cycle. A byte gives zero, one or two results; the
// four-entry result queue drains one per cycle, so only bytes that give two
// results can slow the input when the receiver takes every result at once.
// When the receiver stalls, the queue fills and the input stalls once fewer
// than two entries are free; the head result holds steady meanwhile.
// Configuration writes on wr_en/wr_index/wr_data take effect at the start
// of the next message. Reset restores the default registers, empties the
// queue and returns the parser to waiting for a command.
module led_command_text_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lctp_pkg::CharW-1:0]   char_in,
    input  logic                         last_byte,
    input  logic                         wr_en,
    input  logic [lctp_pkg::CfgIdxW-1:0] wr_index,
    input  logic [lctp_pkg::ColW-1:0]    wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [7:0]                   zone_mask,
    output logic [7:0]                   red,
    output logic [7:0]                   green,
    output logic [7:0]                   blue,
    output logic [7:0]                   mode_value,
    output logic [7:0]                   speed_value,
    output logic [7:0]                   brightness_value,
    output logic [7:0]                   direction_value,
    output logic [1:0]                   error_code,
    output logic                         run_end
);
    import lctp_pkg::*;

    res_wr_t res_wr;
    res_t    head;
    logic    room;

    lctp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .last_byte (last_byte),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .room      (room),
        .res_wr    (res_wr)
    );

    lctp_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_wr    (res_wr),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind             = head.kind;
    assign zone_mask        = head.zone_mask;
    assign red              = head.rgb[23:16];
    assign green            = head.rgb[15:8];
    assign blue             = head.rgb[7:0];
    assign mode_value       = head.pf[0];
    assign speed_value      = head.pf[1];
    assign brightness_value = head.pf[2];
    assign direction_value  = head.pf[3];
    assign error_code       = head.code;
    assign run_end          = head.run_end;

endmodule

>>> src/lctp_checker.sv
// Port-level checks on the result channel, bound to the top level.
module lctp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] zone_mask,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] mode_value,
    input logic [7:0] speed_value,
    input logic [7:0] brightness_value,
    input logic [7:0] direction_value,
    input logic [1:0] error_code,
    input logic       run_end
);
    import lctp_pkg::*;

    // A stalled result stays valid with kind, mask, colour, mode, code and run_end unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(zone_mask)
            && $stable(red) && $stable(green) && $stable(blue) && $stable(run_end)
            && $stable(error_code) && $stable(mode_value))
        else $error("stalled result changed");

    // Zone packets carry at most one zone bit and no mode or error fields.
    a_zone_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ZONE |-> $onehot0(zone_mask) && mode_value == 8'd0
            && speed_value == 8'd0 && brightness_value == 8'd0
            && direction_value == 8'd0 && error_code == 2'd0)
        else $error("zone packet with stray fields");

    // An error is always the final result of its byte and carries no zone mask or colour.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> run_end && zone_mask == 8'd0
            && red == 8'd0 && green == 8'd0 && blue == 8'd0)
        else $error("error result malformed");

    // The mode packet closes a message, is the last result of its byte and has no zone mask or error code.
    a_mode_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_MODE |-> run_end && zone_mask == 8'd0
            && error_code == 2'd0)
        else $error("mode packet malformed");

endmodule

bind led_command_text_parser lctp_checker u_lctp_checker (.*);

>>> sim/lctp_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class with a behavioral model of the LED command text parser.
package lctp_tb_pkg;
    import lctp_pkg::*;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    // Where the number being parsed goes; the first four match the mode packet bytes.
    typedef enum logic [2:0] {
        TGT_MODE,
        TGT_SPEED,
        TGT_BRIGHT,
        TGT_DIR,
        TGT_ZONE,
        TGT_MODE_RGB,
        TGT_ZONE_RGB
    } target_t;

    // Results other than errors carry a zero code.
    localparam err_code_t NoCode = ERR_BAD_CMD;

    typedef struct {
        kind_t      kind;
        logic [7:0] zone_mask;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] mode_value;
        logic [7:0] speed_value;
        logic [7:0] brightness_value;
        logic [7:0] direction_value;
        err_code_t  error_code;
        logic       run_end;
    } led_result_t;

    class packet_scoreboard;
        int          errors;
        led_result_t due_packets[$];
        led_result_t byte_packets[$];

        logic [7:0]  preset_fields[4];
        logic [23:0] preset_rgb;
        logic [7:0]  pkt_fields[4];
        logic [23:0] pkt_rgb;

        bit          in_number;
        target_t     target;
        logic [7:0]  acc;
        radix_t      radix;
        logic [1:0]  digits;
        logic [1:0]  col_idx;
        logic [7:0]  zone_bits;
        logic [23:0] zone_rgb;
        bit          dropping;
        bit          msg_open;

        function new();
            preset_fields = '{ResetMode, ResetSpeed, ResetBright, ResetDir};
            preset_rgb = ResetRgb;
            errors = 0;
            zone_bits = 8'h00;
            zone_rgb = 24'h0;
            dropping = 1'b0;
            msg_open = 1'b0;
            clear_parse();
            load_presets();
        endfunction

        function void set_reg(cfg_idx_t idx, logic [23:0] v);
            if (idx == CFG_RGB)
                preset_rgb = v;
            else
                preset_fields[idx] = v[7:0];
        endfunction

        function int due_count();
            return due_packets.size();
        endfunction

        function void clear_parse();
            in_number = 1'b0;
            target = TGT_MODE;
            acc = 8'h00;
            radix = RADIX_DEC;
            digits = 2'd0;
            col_idx = 2'd0;
        endfunction

        function void load_presets();
            pkt_fields = preset_fields;
            pkt_rgb = preset_rgb;
        endfunction

        function void begin_number(target_t t);
            in_number = 1'b1;
            target = t;
            acc = 8'h00;
            radix = RADIX_DEC;
            digits = 2'd0;
        endfunction

        function void add_packet(kind_t k, logic [7:0] mask, logic [23:0] rgb, bit with_fields,
                                 err_code_t code);
            led_result_t r;
            if (byte_packets.size() >= 2)
                return;
            r.kind = k;
            r.zone_mask = mask;
            r.red = rgb[23:16];
            r.green = rgb[15:8];
            r.blue = rgb[7:0];
            r.mode_value = with_fields ? pkt_fields[TGT_MODE] : 8'h00;
            r.speed_value = with_fields ? pkt_fields[TGT_SPEED] : 8'h00;
            r.brightness_value = with_fields ? pkt_fields[TGT_BRIGHT] : 8'h00;
            r.direction_value = with_fields ? pkt_fields[TGT_DIR] : 8'h00;
            r.error_code = code;
            r.run_end = 1'b0;
            byte_packets.push_back(r);
        endfunction

        function logic [23:0] put_colour(logic [23:0] rgb, logic [7:0] n);
            case (col_idx)
                2'd0: rgb[23:16] = n;
                2'd1: rgb[15:8] = n;
                default: rgb[7:0] = n;
            endcase
            return rgb;
        endfunction

        function void end_number();
            in_number = 1'b0;
            case (target)
                TGT_ZONE:
                begin
                    zone_bits = (acc >= 1 && acc <= 8) ? 8'h01 << (acc - 8'd1) : 8'h00;
                    col_idx = 2'd0;
                    begin_number(TGT_ZONE_RGB);
                end
                TGT_MODE_RGB:
                begin
                    pkt_rgb = put_colour(pkt_rgb, acc);
                    if (col_idx < 2)
                    begin
                        col_idx++;
                        begin_number(TGT_MODE_RGB);
                    end
                end
                TGT_ZONE_RGB:
                begin
                    zone_rgb = put_colour(zone_rgb, acc);
                    if (col_idx < 2)
                    begin
                        col_idx++;
                        begin_number(TGT_ZONE_RGB);
                    end
                    else
                        add_packet(KIND_ZONE, zone_bits, zone_rgb, 1'b0, NoCode);
                end
                default: pkt_fields[target] = acc;
            endcase
        endfunction

        function int digit_of(logic [7:0] c);
            if (radix == RADIX_OCT)
                return (c >= "0" && c <= "7") ? int'(c) - int'("0") : -1;
            if (c >= "0" && c <= "9")
                return int'(c) - int'("0");
            if (radix == RADIX_HEX && c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            return -1;
        endfunction

        function int base_of();
            case (radix)
                RADIX_OCT: return 8;
                RADIX_HEX: return 16;
                default: return 10;
            endcase
        endfunction

        function bit start_command(logic [7:0] c, output err_code_t code);
            code = NoCode;
            case (c)
                " ", "\n": ;
                "m": begin_number(TGT_MODE);
                "v": begin_number(TGT_SPEED);
                "b": begin_number(TGT_BRIGHT);
                "d": begin_number(TGT_DIR);
                "c":
                begin
                    col_idx = 2'd0;
                    begin_number(TGT_MODE_RGB);
                end
                "z": begin_number(TGT_ZONE);
                default:
                begin
                    code = ERR_BAD_CMD;
                    return 1'b1;
                end
            endcase
            return 1'b0;
        endfunction

        // A byte that ends a number is read a second time, as command or next number.
        function bit parse_char(logic [7:0] c, output err_code_t code);
            int d;
            int v;
            code = NoCode;
            for (int pass = 0; pass < 2; pass++)
            begin
                if (!in_number)
                    return start_command(c, code);
                if (c == " " && digits == 0)
                    return 1'b0;
                if (c == "x" && acc == 0)
                begin
                    if (digits == 0)
                    begin
                        radix = RADIX_OCT;
                        return 1'b0;
                    end
                    if (digits == 1)
                    begin
                        radix = RADIX_HEX;
                        return 1'b0;
                    end
                    code = ERR_MISPLACED_X;
                    return 1'b1;
                end
                d = digit_of(c);
                if (d >= 0)
                begin
                    v = int'(acc) * base_of() + d;
                    if (v > 255)
                    begin
                        code = ERR_RANGE;
                        return 1'b1;
                    end
                    acc = v[7:0];
                    if (digits < 2)
                        digits++;
                    return 1'b0;
                end
                if (digits == 0)
                begin
                    code = ERR_NO_NUMBER;
                    return 1'b1;
                end
                end_number();
            end
            return 1'b0;
        endfunction

        function bit close_message(output err_code_t code);
            code = NoCode;
            if (in_number)
            begin
                if (digits == 0)
                begin
                    code = ERR_NO_NUMBER;
                    return 1'b1;
                end
                end_number();
                if (in_number)
                begin
                    code = ERR_NO_NUMBER;
                    return 1'b1;
                end
            end
            add_packet(KIND_MODE, 8'h00, pkt_rgb, 1'b1, NoCode);
            return 1'b0;
        endfunction

        function void note_char(logic [7:0] ch, logic last);
            logic [7:0] c;
            bit         failed;
            err_code_t  code;
            // After an error the rest of the message is swallowed silently.
            if (dropping)
            begin
                if (last)
                begin
                    dropping = 1'b0;
                    msg_open = 1'b0;
                end
                return;
            end
            if (!msg_open)
            begin
                load_presets();
                clear_parse();
                msg_open = 1'b1;
            end
            c = ch;
            if (c >= "A" && c <= "Z")
                c = c + 8'd32;
            byte_packets.delete();
            failed = parse_char(c, code);
            if (!failed && last)
                failed = close_message(code);
            if (failed)
            begin
                add_packet(KIND_ERROR, 8'h00, 24'h0, 1'b0, code);
                clear_parse();
                msg_open = 1'b0;
                dropping = !last;
            end
            else if (last)
            begin
                clear_parse();
                msg_open = 1'b0;
            end
            if (byte_packets.size() > 0)
                byte_packets[byte_packets.size() - 1].run_end = 1'b1;
            foreach (byte_packets[i])
                due_packets.push_back(byte_packets[i]);
        endfunction

        function void compare(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_packet(led_result_t got);
            led_result_t want;
            if (due_packets.size() == 0)
            begin
                $error("result transfer with nothing expected: kind %0d", got.kind);
                errors++;
                return;
            end
            want = due_packets.pop_front();
            compare("kind", want.kind, got.kind);
            compare("zone_mask", want.zone_mask, got.zone_mask);
            compare("red", want.red, got.red);
            compare("green", want.green, got.green);
            compare("blue", want.blue, got.blue);
            compare("mode_value", want.mode_value, got.mode_value);
            compare("speed_value", want.speed_value, got.speed_value);
            compare("brightness_value", want.brightness_value, got.brightness_value);
            compare("direction_value", want.direction_value, got.direction_value);
            compare("error_code", want.error_code, got.error_code);
            compare("run_end", want.run_end, got.run_end);
        endfunction
    endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives text messages into the parser and checks every result packet.
module tb_top;
    import lctp_pkg::*;
    import lctp_tb_pkg::*;

    localparam int QuietLimit    = 2000;
    localparam int SettleCycles  = 8;
    localparam int CharsPerPhase = 125;
    localparam int NumPhases     = 4;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CharW-1:0]    char_in   = '0;
    logic                last_byte = 1'b0;
    logic                wr_en     = 1'b0;
    logic [CfgIdxW-1:0]  wr_index  = '0;
    logic [ColW-1:0]     wr_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          kind;
    logic [7:0]          zone_mask;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          mode_value;
    logic [7:0]          speed_value;
    logic [7:0]          brightness_value;
    logic [7:0]          direction_value;
    logic [1:0]          error_code;
    logic                run_end;

    packet_scoreboard    sb;
    led_result_t         seen;
    logic [7:0]          text_q[$];
    int                  chars_sent = 0;
    int                  send_gap_pct = 0;
    int                  stall_pct = 0;
    int                  quiet_cycles = 0;
    int                  gap_table[NumPhases]   = '{0, 73, 0, 17};
    int                  stall_table[NumPhases] = '{0, 0, 73, 17};

    led_command_text_parser i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .last_byte        (last_byte),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .zone_mask        (zone_mask),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .mode_value       (mode_value),
        .speed_value      (speed_value),
        .brightness_value (brightness_value),
        .direction_value  (direction_value),
        .error_code       (error_code),
        .run_end          (run_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: check each transfer, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.kind = kind_t'(kind);
            seen.zone_mask = zone_mask;
            seen.red = red;
            seen.green = green;
            seen.blue = blue;
            seen.mode_value = mode_value;
            seen.speed_value = speed_value;
            seen.brightness_value = brightness_value;
            seen.direction_value = direction_value;
            seen.error_code = err_code_t'(error_code);
            seen.run_end = run_end;
            sb.check_packet(seen);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] c, logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(bit close);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], close && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    function automatic void push_text(string s, bit vary_case);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (vary_case && ch >= "a" && ch <= "z" && $urandom_range(3) == 0)
                ch = ch - 8'd32;
            text_q.push_back(ch);
        end
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 20)
            return 255;
        if (r < 24)
            return $urandom_range(999, 256);
        return $urandom_range(255);
    endfunction

    function automatic string number_text(int v);
        string s;
        case ($urandom_range(3))
            0: s = $sformatf("%0d", v);
            1: s = $sformatf("0%0d", v);
            2: s = $sformatf("x%0o", v);
            default: s = $sformatf("0x%0h", v);
        endcase
        repeat ($urandom_range(2))
            s = {" ", s};
        return s;
    endfunction

    function automatic string colour_text();
        return {number_text(pick_value()), " ", number_text(pick_value()), " ",
                number_text(pick_value())};
    endfunction

    function automatic string command_text();
        case ($urandom_range(5))
            0: return {"m", number_text(pick_value())};
            1: return {"v", number_text(pick_value())};
            2: return {"b", number_text(pick_value())};
            3: return {"d", number_text(pick_value())};
            4: return {"c", colour_text()};
            default: return {"z", number_text($urandom_range(9)), " ", colour_text()};
        endcase
    endfunction

    // A well-formed message whose numbers may exceed 255; it may end right inside its last number.
    function automatic void build_message();
        int n;
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
        begin
            push_text(command_text(), 1'b1);
            if (i < n - 1 || $urandom_range(1) == 1)
                push_text(($urandom_range(3) == 0) ? "\n" : " ", 1'b0);
        end
    endfunction

    task automatic send_random_message();
        int pick;
        int cut;
        pick = $urandom_range(99);
        if (pick >= 92)
        begin
            repeat ($urandom_range(5, 1))
                text_q.push_back(8'($urandom));
        end
        else
        begin
            build_message();
            if (pick >= 84)
            begin
                cut = $urandom_range(text_q.size(), 1);
                while (text_q.size() > cut)
                    void'(text_q.pop_back());
            end
            else if (pick >= 74)
                text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
        end
        send_text(1'b1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_count() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    // Low extremes first, then high extremes, then random settings; narrow
    // registers also see random upper data bits, which they must ignore.
    function automatic logic [23:0] preset_value(int phase, bit full_width);
        logic [23:0] v;
        v = 24'($urandom);
        if (phase == 0)
            v = full_width ? 24'h000000 : {v[23:8], 8'h00};
        else if (phase == 1)
            v = full_width ? 24'hffffff : {v[23:8], 8'hff};
        return v;
    endfunction

    task automatic load_preset_regs(int phase);
        write_reg(CFG_MODE, preset_value(phase, 1'b0));
        write_reg(CFG_SPEED, preset_value(phase, 1'b0));
        write_reg(CFG_BRIGHT, preset_value(phase, 1'b0));
        write_reg(CFG_DIR, preset_value(phase, 1'b0));
        write_reg(CFG_RGB, preset_value(phase, 1'b1));
        wr_en <= 1'b0;
    endtask

    initial
    begin
        int phase_end;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bad zone number with upper case, hex and octal, ending inside the last number.
        push_text("Z9 0Xff x7 0", 1'b0);
        send_text(1'b1);
        // The first zero of 00x is a bad command, so the rest and the trailing byte must be swallowed.
        push_text("00x", 1'b0);
        text_q.push_back(8'h00);
        send_text(1'b1);
        push_text("m256", 1'b0);
        send_text(1'b1);
        text_q.push_back(8'hff);
        send_text(1'b1);
        push_text("c", 1'b0);
        send_text(1'b1);
        push_text(" \n", 1'b0);
        send_text(1'b1);
        push_text("d\n", 1'b0);
        send_text(1'b1);

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            settle();
            send_gap_pct = gap_table[phase];
            stall_pct = stall_table[phase];
            load_preset_regs(phase);
            phase_end = chars_sent + CharsPerPhase;
            while (chars_sent < phase_end)
                send_random_message();
            // Sometimes leave a message open so the next register writes land mid-message.
            if (phase < NumPhases - 1 && $urandom_range(1) == 1)
            begin
                build_message();
                send_text(1'b0);
            end
        end
        settle();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
